// File: rtl/landmark_radius_vote_table_core_macros.svh
// Assertion macros shared by the landmark vote table RTL.
// Depends on the including module having clk_i and rst_ni in scope.
`ifndef LANDMARK_RADIUS_VOTE_TABLE_CORE_MACROS_SVH
`define LANDMARK_RADIUS_VOTE_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LRVT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define LRVT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define LRVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LRVT_ASSERT(lbl, expr, msg)
`define LRVT_ASSERT_IMPL(lbl, ante, cons, msg)
`define LRVT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/lrvt_pkg.sv
// Shared constants, codes and control structs for the landmark vote table.
// No dependencies; compiled before every other RTL file.
`default_nettype none
package lrvt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COORD_W     = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int HIT_W       = 16;
  localparam int SLOT_W      = 6;
  localparam int GATE_W      = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int SQ_W        = 2 * COORD_W;

  localparam logic [GATE_W-1:0] GATE_RESET    = GATE_W'(5898);
  localparam logic [HIT_W-1:0]  CONFIRM_RESET = HIT_W'(50);
  localparam logic [HIT_W-1:0]  HIT_MAX       = {HIT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GATE_RADIUS_SQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    ST_MATCHED = 2'd0,
    ST_ADDED   = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    issue;
    logic    flush;
    logic    take_hit;
    logic    commit;
    status_e kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_more;
    logic pipe_busy;
    logic hit;
    logic full;
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/lrvt_in_if.sv
// Input channel: one detected marker per item, valid/ready handshake.
// Depends on lrvt_pkg for the coordinate width.
`default_nettype none
interface lrvt_in_if;
  import lrvt_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;
  logic                       yellow;

  modport source (output valid, point_x, point_y, yellow, input ready);
  modport sink   (input valid, point_x, point_y, yellow, output ready);
endinterface
`default_nettype wire

// File: rtl/lrvt_out_if.sv
// Result channel: one vote result per item, valid/ready handshake.
// Depends on lrvt_pkg for field widths.
`default_nettype none
interface lrvt_out_if;
  import lrvt_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  out_x;
  logic signed [COORD_W-1:0]  out_y;
  logic                       out_yellow;
  logic                       confirmed;
  logic [1:0]                 status;
  logic [SLOT_W-1:0]          slot;

  modport source (output valid, out_x, out_y, out_yellow, confirmed, status, slot,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_yellow, confirmed, status, slot,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/lrvt_ctrl.sv
// Controller of the landmark vote table: sequences scan, commit and result hand-off.
// Depends on lrvt_pkg and the assertion macro header.
`default_nettype none
`include "landmark_radius_vote_table_core_macros.svh"
module lrvt_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire lrvt_pkg::stat_t stat_i,
  output lrvt_pkg::cmd_t       cmd_o
);
  import lrvt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_MATCH  = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_DROP   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // next state and datapath commands
  always_comb begin
    state_d        = state_q;
    cmd_o.load     = in_acc;
    cmd_o.issue    = 1'b0;
    cmd_o.flush    = 1'b0;
    cmd_o.take_hit = 1'b0;
    cmd_o.commit   = 1'b0;
    cmd_o.kind     = ST_DROPPED;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.take_hit = 1'b1;
          cmd_o.flush    = 1'b1;
          state_d        = S_MATCH;
        end else begin
          cmd_o.issue = stat_i.issue_more;
          if (!stat_i.issue_more && !stat_i.pipe_busy) begin
            state_d = stat_i.full ? S_DROP : S_APPEND;
          end
        end
      end
      S_MATCH: begin
        cmd_o.kind   = ST_MATCHED;
        cmd_o.commit = out_free;
        if (out_free) state_d = S_IDLE;
      end
      S_APPEND: begin
        cmd_o.kind   = ST_ADDED;
        cmd_o.commit = out_free;
        if (out_free) state_d = S_IDLE;
      end
      S_DROP: begin
        cmd_o.kind   = ST_DROPPED;
        cmd_o.commit = out_free;
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold the result valid until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `LRVT_ASSERT_IMPL(a_hit_in_scan, stat_i.hit, state_q == S_SCAN, "hit outside scan")
  `LRVT_ASSERT_NEXT(a_accept_scans, in_acc, state_q == S_SCAN, "accepted item not scanned")
  `LRVT_ASSERT_IMPL(a_append_room, state_q == S_APPEND, !stat_i.full, "append into full table")

endmodule
`default_nettype wire

// File: rtl/lrvt_dpath.sv
// Datapath of the landmark vote table: landmark memories, distance pipeline,
// hit counters, configuration registers and result register. Depends on lrvt_pkg and the assertion macro header.
`default_nettype none
`include "landmark_radius_vote_table_core_macros.svh"
module lrvt_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lrvt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lrvt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic signed [lrvt_pkg::COORD_W-1:0] point_x_i,
  input  wire logic signed [lrvt_pkg::COORD_W-1:0] point_y_i,
  input  wire logic                          yellow_i,
  input  wire lrvt_pkg::cmd_t                cmd_i,
  output lrvt_pkg::stat_t                    stat_o,
  output logic signed [lrvt_pkg::COORD_W-1:0] out_x_o,
  output logic signed [lrvt_pkg::COORD_W-1:0] out_y_o,
  output logic                               out_yellow_o,
  output logic                               confirmed_o,
  output logic [1:0]                         status_o,
  output logic [lrvt_pkg::SLOT_W-1:0]        slot_o
);
  import lrvt_pkg::*;

  // configuration
  logic [GATE_W-1:0] gate_q;
  logic [HIT_W-1:0]  confirm_q;

  // current item and table fill
  logic signed [COORD_W-1:0] pt_x_q, pt_y_q;
  logic                      pt_yel_q;
  logic [CNT_W-1:0]          total_q;
  logic [CNT_W-1:0]          issue_idx_q;
  logic [IDX_W-1:0]          rd_addr;

  // memories: coordinates {x, y}, counters {yellow, blue}
  logic [2*COORD_W-1:0] coord_mem [TABLE_DEPTH];
  logic [2*HIT_W-1:0]   cnt_mem   [TABLE_DEPTH];

  // scan pipeline
  logic                      v1_q, v2_q, v3_q;
  logic [IDX_W-1:0]          idx1_q, idx2_q, idx3_q;
  logic [2*COORD_W-1:0]      crd1_q;
  logic [2*HIT_W-1:0]        cnt1_q, cnt2_q, cnt3_q;
  logic [COORD_W:0]          dx, dy, adx, ady;
  logic [COORD_W-1:0]        adx2_q, ady2_q;
  logic                      over2_q, over3_q;
  logic [SQ_W-1:0]           sqx3_q, sqy3_q;
  logic [SQ_W:0]             dist_sq;
  logic                      hit;

  // match capture and counter update
  logic [IDX_W-1:0]          m_idx_q;
  logic [2*HIT_W-1:0]        m_cnt_q;
  logic [HIT_W-1:0]          cnt_sel, cnt_new;
  logic                      cnt_sat;
  logic                      confirm_now;
  logic [2*HIT_W-1:0]        cnt_word;
  logic [IDX_W-1:0]          app_addr;
  logic                      do_match, do_append;

  // result register
  logic signed [COORD_W-1:0] out_x_q, out_y_q;
  logic                      out_yel_q, conf_q;
  status_e                   status_q;
  logic [SLOT_W-1:0]         slot_q;

  assign rd_addr   = issue_idx_q[IDX_W-1:0];
  assign app_addr  = total_q[IDX_W-1:0];
  assign do_match  = cmd_i.commit && (cmd_i.kind == ST_MATCHED);
  assign do_append = cmd_i.commit && (cmd_i.kind == ST_ADDED);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q    <= GATE_RESET;
      confirm_q <= CONFIRM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GATE_RADIUS_SQ: gate_q    <= cfg_wdata_i[GATE_W-1:0];
        REG_CONFIRM_COUNT:  confirm_q <= cfg_wdata_i[HIT_W-1:0];
      endcase
    end
  end

  // control registers: fill count, scan address, pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      issue_idx_q <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
    end else begin
      if (do_append) total_q <= total_q + CNT_W'(1);
      if (cmd_i.load) begin
        issue_idx_q <= '0;
      end else if (cmd_i.issue) begin
        issue_idx_q <= issue_idx_q + CNT_W'(1);
      end
      v1_q <= cmd_i.issue && !cmd_i.flush;
      v2_q <= v1_q && !cmd_i.flush;
      v3_q <= v2_q && !cmd_i.flush;
    end
  end

  // latch the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pt_x_q   <= point_x_i;
      pt_y_q   <= point_y_i;
      pt_yel_q <= yellow_i;
    end
  end

  // memories: registered read during scan, write on a match or append commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      crd1_q <= coord_mem[rd_addr];
      cnt1_q <= cnt_mem[rd_addr];
      idx1_q <= rd_addr;
    end
    if (do_append) begin
      coord_mem[app_addr] <= {pt_x_q, pt_y_q};
    end
    if (do_append || do_match) begin
      cnt_mem[do_match ? m_idx_q : app_addr] <= cnt_word;
    end
  end

  // stage 2: absolute coordinate differences
  always_comb begin
    dx  = {pt_x_q[COORD_W-1], pt_x_q} - {crd1_q[2*COORD_W-1], crd1_q[2*COORD_W-1:COORD_W]};
    dy  = {pt_y_q[COORD_W-1], pt_y_q} - {crd1_q[COORD_W-1], crd1_q[COORD_W-1:0]};
    adx = dx[COORD_W] ? -dx : dx;
    ady = dy[COORD_W] ? -dy : dy;
  end

  always_ff @(posedge clk_i) begin
    adx2_q  <= adx[COORD_W-1:0];
    ady2_q  <= ady[COORD_W-1:0];
    over2_q <= adx[COORD_W] || ady[COORD_W];
    cnt2_q  <= cnt1_q;
    idx2_q  <= idx1_q;
  end

  // stage 3: squares
  always_ff @(posedge clk_i) begin
    sqx3_q  <= SQ_W'(adx2_q) * SQ_W'(adx2_q);
    sqy3_q  <= SQ_W'(ady2_q) * SQ_W'(ady2_q);
    over3_q <= over2_q;
    cnt3_q  <= cnt2_q;
    idx3_q  <= idx2_q;
  end

  // stage 4: sum and gate compare
  assign dist_sq = {1'b0, sqx3_q} + {1'b0, sqy3_q};
  assign hit     = v3_q && !over3_q && (dist_sq < (SQ_W + 1)'(gate_q));

  always_comb begin
    stat_o.issue_more = (issue_idx_q < total_q);
    stat_o.pipe_busy  = v1_q || v2_q || v3_q;
    stat_o.hit        = hit;
    stat_o.full       = (total_q == CNT_W'(TABLE_DEPTH));
  end

  // capture the first matching landmark
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_hit) begin
      m_idx_q <= idx3_q;
      m_cnt_q <= cnt3_q;
    end
  end

  // saturating counter bump for the item's colour
  always_comb begin
    cnt_sel     = pt_yel_q ? m_cnt_q[2*HIT_W-1:HIT_W] : m_cnt_q[HIT_W-1:0];
    cnt_sat     = (cnt_sel == HIT_MAX);
    cnt_new     = cnt_sat ? cnt_sel : cnt_sel + HIT_W'(1);
    confirm_now = !cnt_sat && (cnt_new == confirm_q);
    if (do_match) begin
      cnt_word = pt_yel_q ? {cnt_new, m_cnt_q[HIT_W-1:0]}
                          : {m_cnt_q[2*HIT_W-1:HIT_W], cnt_new};
    end else begin
      cnt_word = pt_yel_q ? {HIT_W'(1), HIT_W'(0)} : {HIT_W'(0), HIT_W'(1)};
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_x_q   <= pt_x_q;
      out_y_q   <= pt_y_q;
      out_yel_q <= pt_yel_q;
      status_q  <= cmd_i.kind;
      conf_q    <= do_match && confirm_now;
      if (do_match) begin
        slot_q <= SLOT_W'(m_idx_q);
      end else if (do_append) begin
        slot_q <= SLOT_W'(app_addr);
      end else begin
        slot_q <= '0;
      end
    end
  end

  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_yellow_o = out_yel_q;
  assign confirmed_o  = conf_q;
  assign status_o     = status_q;
  assign slot_o       = slot_q;

  `LRVT_ASSERT(a_total_bound, total_q <= CNT_W'(TABLE_DEPTH), "table count past depth")
  `LRVT_ASSERT_IMPL(a_issue_below_total, cmd_i.issue, issue_idx_q < total_q,
                    "scan read past stored landmarks")
  `LRVT_ASSERT_NEXT(a_append_grows, do_append, total_q == $past(total_q) + CNT_W'(1),
                    "append did not grow table")

endmodule
`default_nettype wire

// File: rtl/landmark_radius_vote_table_core.sv
// Landmark vote table: each accepted item is compared with the stored landmarks, one entry
// per cycle through a three-stage distance pipeline, until the first hit or the last stored
// landmark; the controller then commits a match, an append or a drop.
// A new item is taken only once the previous one is committed; it is taken while the previous
// result waits, and commit holds while that result is not yet taken.
// Reset clears the landmark count and controller and loads the configuration defaults; table memories stay unknown.
`default_nettype none
module landmark_radius_vote_table_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lrvt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lrvt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  lrvt_in_if.sink                              in_ch,
  lrvt_out_if.source                           out_ch
);
  import lrvt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  lrvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // table, distance pipeline and result
  lrvt_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .point_x_i    (in_ch.point_x),
    .point_y_i    (in_ch.point_y),
    .yellow_i     (in_ch.yellow),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_x_o      (out_ch.out_x),
    .out_y_o      (out_ch.out_y),
    .out_yellow_o (out_ch.out_yellow),
    .confirmed_o  (out_ch.confirmed),
    .status_o     (out_ch.status),
    .slot_o       (out_ch.slot)
  );

endmodule
`default_nettype wire
